// File: design/aled_pkg.sv
// Shared types and constants for the addressable LED serial driver.
// No dependencies.
package aled_pkg;

  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_COUNT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHTNESS   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ZERO_HIGH    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ONE_HIGH     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_PERIOD   = 3'd4;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  localparam logic [1:0] BYTE_GREEN = 2'd0;
  localparam logic [1:0] BYTE_RED   = 2'd1;
  localparam logic [1:0] BYTE_BLUE  = 2'd2;

  localparam logic [7:0] RESET_BRIGHTNESS = 8'd255;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
  } res_t;

endpackage

// File: design/addressable_led_serial_driver.sv
// Single-wire addressable LED driver. Every request returns exactly one result.
// A tick request (mode 0) advances the LED waveform by one step and reports the
// line level and whether the frame is still in progress; a color write
// (mode 1) scales the color by brightness and starts a frame to pixel_count
// pixels, or is rejected while a frame is running. A request is taken every
// clock cycle when the result side keeps up; each result passes through the
// input register, the state update and then the result register before it is presented.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while no request is in flight, as the block does not enforce this.
// Depends on aled_pkg, aled_cfg, aled_core and aled_out_reg.
module addressable_led_serial_driver #(
  parameter int PIXEL_COUNT_BITS = 10,
  parameter int TIMING_BITS      = 16,
  localparam int CFG_DATA_BITS   =
    (PIXEL_COUNT_BITS > TIMING_BITS) ? PIXEL_COUNT_BITS : TIMING_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic [7:0]                          red,
  input  logic [7:0]                          green,
  input  logic [7:0]                          blue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                line_level,
  output logic                                busy_res,
  output logic                                rejected,
  input  logic                                cfg_we,
  input  logic [aled_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]            cfg_data
);

  logic                        req_valid;
  logic                        req_mode;
  logic [7:0]                  req_red, req_green, req_blue;
  logic                        adv, proc, accept;
  logic [PIXEL_COUNT_BITS-1:0] pixel_count;
  logic [7:0]                  brightness;
  logic [TIMING_BITS-1:0]      zero_high_cycles, one_high_cycles, bit_period_cycles;
  aled_pkg::res_t              res, res_q;

  assign in_ready = !req_valid || adv;
  assign accept   = in_valid && in_ready;
  assign proc     = req_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (adv) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode  <= mode;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
    end
  end

  aled_cfg #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
    .TIMING_BITS      (TIMING_BITS),
    .CFG_DATA_BITS    (CFG_DATA_BITS)
  ) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pixel_count       (pixel_count),
    .brightness        (brightness),
    .zero_high_cycles  (zero_high_cycles),
    .one_high_cycles   (one_high_cycles),
    .bit_period_cycles (bit_period_cycles)
  );

  aled_core #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
    .TIMING_BITS      (TIMING_BITS)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .proc              (proc),
    .mode              (req_mode),
    .red               (req_red),
    .green             (req_green),
    .blue              (req_blue),
    .pixel_count       (pixel_count),
    .brightness        (brightness),
    .zero_high_cycles  (zero_high_cycles),
    .one_high_cycles   (one_high_cycles),
    .bit_period_cycles (bit_period_cycles),
    .res               (res)
  );

  aled_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (proc),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q),
    .adv       (adv)
  );

  assign line_level = res_q.line_level;
  assign busy_res   = res_q.busy_res;
  assign rejected   = res_q.rejected;

endmodule

// File: design/aled_cfg.sv
// Configuration register file of the LED driver.
// Depends on aled_pkg for register indexes.
module aled_cfg #(
  parameter int PIXEL_COUNT_BITS = 10,
  parameter int TIMING_BITS      = 16,
  parameter int CFG_DATA_BITS    = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [aled_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]             cfg_data,
  output logic [PIXEL_COUNT_BITS-1:0]          pixel_count,
  output logic [7:0]                           brightness,
  output logic [TIMING_BITS-1:0]               zero_high_cycles,
  output logic [TIMING_BITS-1:0]               one_high_cycles,
  output logic [TIMING_BITS-1:0]               bit_period_cycles
);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count       <= PIXEL_COUNT_BITS'(1);
      brightness        <= aled_pkg::RESET_BRIGHTNESS;
      zero_high_cycles  <= TIMING_BITS'(51);
      one_high_cycles   <= TIMING_BITS'(106);
      bit_period_cycles <= TIMING_BITS'(160);
    end else if (cfg_we) begin
      unique case (cfg_index)
        aled_pkg::REG_PIXEL_COUNT: pixel_count       <= cfg_data[PIXEL_COUNT_BITS-1:0];
        aled_pkg::REG_BRIGHTNESS:  brightness        <= cfg_data[7:0];
        aled_pkg::REG_ZERO_HIGH:   zero_high_cycles  <= cfg_data[TIMING_BITS-1:0];
        aled_pkg::REG_ONE_HIGH:    one_high_cycles   <= cfg_data[TIMING_BITS-1:0];
        aled_pkg::REG_BIT_PERIOD:  bit_period_cycles <= cfg_data[TIMING_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/aled_core.sv
// Frame state and per-request logic: color scaling, bit slot timing, line level.
// Depends on aled_pkg for result type and codes.
module aled_core #(
  parameter int PIXEL_COUNT_BITS = 10,
  parameter int TIMING_BITS      = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        proc,
  input  logic                        mode,
  input  logic [7:0]                  red,
  input  logic [7:0]                  green,
  input  logic [7:0]                  blue,
  input  logic [PIXEL_COUNT_BITS-1:0] pixel_count,
  input  logic [7:0]                  brightness,
  input  logic [TIMING_BITS-1:0]      zero_high_cycles,
  input  logic [TIMING_BITS-1:0]      one_high_cycles,
  input  logic [TIMING_BITS-1:0]      bit_period_cycles,
  output aled_pkg::res_t              res
);

  logic                        sending, sending_next;
  logic [TIMING_BITS-1:0]      cycle_count, cycle_count_next;
  logic [2:0]                  bit_index, bit_index_next;
  logic [1:0]                  byte_index, byte_index_next;
  logic [PIXEL_COUNT_BITS-1:0] pixels_left, pixels_left_next;
  logic [7:0]                  scaled_g, scaled_r, scaled_b;
  logic [7:0]                  scaled_g_next, scaled_r_next, scaled_b_next;

  logic [15:0]            prod_g, prod_r, prod_b;
  logic [7:0]             cur_byte;
  logic                   cur_bit;
  logic [TIMING_BITS-1:0] high_time, slot_len, first_high;
  logic                   slot_end;
  logic                   level;

  always_comb begin
    prod_g = 16'(green) * 16'(brightness);
    prod_r = 16'(red) * 16'(brightness);
    prod_b = 16'(blue) * 16'(brightness);

    unique case (byte_index)
      aled_pkg::BYTE_RED:  cur_byte = scaled_r;
      aled_pkg::BYTE_BLUE: cur_byte = scaled_b;
      default:             cur_byte = scaled_g;
    endcase
    cur_bit   = cur_byte[3'd7 - bit_index];
    high_time = cur_bit ? one_high_cycles : zero_high_cycles;
    slot_len  = (high_time > bit_period_cycles) ? high_time : bit_period_cycles;
    if (slot_len == '0) slot_len = TIMING_BITS'(1);
    slot_end  = ({1'b0, cycle_count} + (TIMING_BITS+1)'(1)) >= {1'b0, slot_len};
    level     = sending && (cycle_count < high_time);

    first_high = prod_g[15] ? one_high_cycles : zero_high_cycles;

    sending_next     = sending;
    cycle_count_next = cycle_count;
    bit_index_next   = bit_index;
    byte_index_next  = byte_index;
    pixels_left_next = pixels_left;
    scaled_g_next    = scaled_g;
    scaled_r_next    = scaled_r;
    scaled_b_next    = scaled_b;
    res.line_level   = level;
    res.rejected     = 1'b0;

    if (mode == aled_pkg::MODE_TICK) begin
      if (sending) begin
        if (!slot_end) begin
          cycle_count_next = cycle_count + TIMING_BITS'(1);
        end else begin
          cycle_count_next = '0;
          bit_index_next   = bit_index + 3'd1;
          if (bit_index == 3'd7) begin
            if (byte_index == aled_pkg::BYTE_BLUE) begin
              byte_index_next  = aled_pkg::BYTE_GREEN;
              pixels_left_next = pixels_left - PIXEL_COUNT_BITS'(1);
              if (pixels_left == PIXEL_COUNT_BITS'(1)) sending_next = 1'b0;
            end else begin
              byte_index_next = byte_index + 2'd1;
            end
          end
        end
      end
    end else if (sending) begin
      res.rejected = 1'b1;
    end else begin
      scaled_g_next    = prod_g[15:8];
      scaled_r_next    = prod_r[15:8];
      scaled_b_next    = prod_b[15:8];
      cycle_count_next = '0;
      bit_index_next   = '0;
      byte_index_next  = aled_pkg::BYTE_GREEN;
      pixels_left_next = pixel_count;
      sending_next     = (pixel_count != '0);
      res.line_level   = sending_next && (first_high != '0);
    end
    res.busy_res = sending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending     <= 1'b0;
      cycle_count <= '0;
      bit_index   <= '0;
      byte_index  <= aled_pkg::BYTE_GREEN;
      pixels_left <= '0;
      scaled_g    <= '0;
      scaled_r    <= '0;
      scaled_b    <= '0;
    end else if (proc) begin
      sending     <= sending_next;
      cycle_count <= cycle_count_next;
      bit_index   <= bit_index_next;
      byte_index  <= byte_index_next;
      pixels_left <= pixels_left_next;
      scaled_g    <= scaled_g_next;
      scaled_r    <= scaled_r_next;
      scaled_b    <= scaled_b_next;
    end
  end

  a_idle_counters_clear: assert property (@(posedge clk) disable iff (rst)
    !sending |-> (cycle_count == '0 && bit_index == '0 && byte_index == aled_pkg::BYTE_GREEN))
    else $error("counters not cleared while idle");

  a_byte_in_range: assert property (@(posedge clk) disable iff (rst)
    byte_index != 2'd3)
    else $error("byte index out of range");

  a_sending_has_pixels: assert property (@(posedge clk) disable iff (rst)
    sending |-> pixels_left != '0)
    else $error("sending with no pixels left");

  a_frame_starts_on_write: assert property (@(posedge clk) disable iff (rst)
    $rose(sending) |-> $past(proc && mode == aled_pkg::MODE_WRITE))
    else $error("frame started without a color write");

  a_reject_only_busy: assert property (@(posedge clk) disable iff (rst)
    (proc && res.rejected) |-> (sending && res.busy_res))
    else $error("request rejected while idle");

endmodule

// File: design/aled_out_reg.sv
// Result register with valid/ready handshake for the LED driver.
// Depends on aled_pkg for the result type.
module aled_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  aled_pkg::res_t res_in,
  input  logic           out_ready,
  output logic           out_valid,
  output aled_pkg::res_t res_q,
  output logic           adv
);

  assign adv = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && adv) begin
      res_q <= res_in;
    end
  end

endmodule
